// ===== sv/taem_pkg.sv =====
package taem_pkg;

    localparam int NUM_Q       = 7;
    localparam int THR_Q       = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CODE_W      = 6;
    localparam int KIND_W      = 3;
    localparam int PORT_W      = 2;
    localparam int OPT_W       = 2;
    localparam int WORD_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PORT_TAG       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULE_OPTIONS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMITS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VCC_LIMITS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_LIMITS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TXPOWER_LIMITS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RXPOWER_LIMITS = 3'd6;

    localparam logic [KIND_W-1:0] KIND_HI_ALARM = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HI_WARN  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LO_ALARM = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LO_WARN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OK       = 3'd4;

    localparam int OPT_FLAGS = 0;
    localparam int OPT_DWDM  = 1;

    localparam logic [WORD_W-1:0] LASER_TEC_MASK = 16'h003C;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [15:0]        supply_voltage;
        logic [15:0]        laser_bias;
        logic [15:0]        tx_power;
        logic [15:0]        rx_power;
        logic [15:0]        alarm_bits;
        logic [15:0]        warning_bits;
    } t_in;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [CODE_W-1:0] event_code;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [NUM_Q-1:0] en;
        logic [NUM_Q-1:0] hi_a;
        logic [NUM_Q-1:0] hi_w;
        logic [NUM_Q-1:0] lo_a;
        logic [NUM_Q-1:0] lo_w;
    } t_cls;

    typedef struct packed {
        logic [OPT_W-1:0]                  options;
        logic [THR_Q-1:0][CFG_DATA_W-1:0]  limits;
    } t_cfg;

endpackage

// ===== sv/taem_queue.sv =====
module taem_queue #(
    parameter int DEPTH = taem_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  taem_pkg::t_cls  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output taem_pkg::t_cls  o_data,
    output logic            o_avail
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    taem_pkg::t_cls r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/taem_front.sv =====
module taem_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  taem_pkg::t_in   i_item,
    input  taem_pkg::t_cfg  i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output taem_pkg::t_cls  o_cls
);

    logic [taem_pkg::WORD_W-1:0] r_prior_a, n_prior_a;
    logic [taem_pkg::WORD_W-1:0] r_prior_w, n_prior_w;
    logic [taem_pkg::WORD_W-1:0] fa, fw;
    logic [taem_pkg::THR_Q-1:0][15:0] rd;
    logic [15:0] ha, la, hw, lw;
    logic        flag_mode, dwdm, accept;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign o_push    = accept;
    assign flag_mode = i_cfg.options[taem_pkg::OPT_FLAGS];
    assign dwdm      = i_cfg.options[taem_pkg::OPT_DWDM];
    assign fa        = i_item.alarm_bits & r_prior_a;
    assign fw        = i_item.warning_bits & r_prior_w;

    always_comb begin
        rd[0] = i_item.temperature;
        rd[1] = i_item.supply_voltage;
        rd[2] = i_item.laser_bias;
        rd[3] = i_item.tx_power;
        rd[4] = i_item.rx_power;
        o_cls = '0;
        ha = '0;
        la = '0;
        hw = '0;
        lw = '0;
        if (flag_mode) begin
            for (int q = 0; q < taem_pkg::NUM_Q; q++) begin
                o_cls.en[q]   = (q < taem_pkg::THR_Q) || dwdm;
                o_cls.hi_a[q] = fa[15 - 2 * q];
                o_cls.hi_w[q] = fw[15 - 2 * q];
                o_cls.lo_a[q] = fa[14 - 2 * q];
                o_cls.lo_w[q] = fw[14 - 2 * q];
            end
        end else begin
            for (int q = 0; q < taem_pkg::THR_Q; q++) begin
                ha = i_cfg.limits[q][63:48];
                la = i_cfg.limits[q][47:32];
                hw = i_cfg.limits[q][31:16];
                lw = i_cfg.limits[q][15:0];
                o_cls.en[q] = 1'b1;
                if (q == 0) begin
                    o_cls.hi_a[q] = $signed(rd[q]) > $signed(ha);
                    o_cls.hi_w[q] = $signed(rd[q]) > $signed(hw);
                    o_cls.lo_a[q] = $signed(rd[q]) < $signed(la);
                    o_cls.lo_w[q] = $signed(rd[q]) < $signed(lw);
                end else begin
                    o_cls.hi_a[q] = rd[q] > ha;
                    o_cls.hi_w[q] = rd[q] > hw;
                    o_cls.lo_a[q] = rd[q] < la;
                    o_cls.lo_w[q] = rd[q] < lw;
                end
            end
        end
    end

    always_comb begin
        n_prior_a = r_prior_a;
        n_prior_w = r_prior_w;
        if (accept && flag_mode) begin
            if (dwdm) begin
                n_prior_a = i_item.alarm_bits;
                n_prior_w = i_item.warning_bits;
            end else begin
                n_prior_a = i_item.alarm_bits & ~taem_pkg::LASER_TEC_MASK;
                n_prior_w = i_item.warning_bits & ~taem_pkg::LASER_TEC_MASK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_a <= '0;
            r_prior_w <= '0;
        end else begin
            r_prior_a <= n_prior_a;
            r_prior_w <= n_prior_w;
        end
    end

endmodule

// ===== sv/taem_back.sv =====
module taem_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_avail,
    input  taem_pkg::t_cls               i_cls,
    output logic                         o_pop,
    input  logic [taem_pkg::PORT_W-1:0]  i_port_tag,
    output logic                         o_valid,
    input  logic                         i_ready,
    output taem_pkg::t_out               o_item
);

    localparam int NQ = taem_pkg::NUM_Q;
    localparam int SW = $clog2(NQ);

    logic [NQ-1:0] r_la_hi, n_la_hi, r_la_lo, n_la_lo;
    logic [NQ-1:0] r_lw_hi, n_lw_hi, r_lw_lo, n_lw_lo;
    logic [NQ-1:0] r_pend, n_pend, ev;
    logic [NQ-1:0][taem_pkg::CODE_W-1:0] r_code, n_code;
    logic [taem_pkg::KIND_W-1:0] kind;
    logic [NQ-1:0] low, rest;
    logic [SW-1:0] sel;
    logic          send;
    logic          r_out_valid;
    taem_pkg::t_out r_out;

    assign o_pop   = i_avail && (r_pend == '0);
    assign send    = (r_pend != '0) && (!r_out_valid || i_ready);
    assign low     = r_pend & (~r_pend + NQ'(1));
    assign rest    = r_pend & ~low;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        sel = '0;
        for (int q = NQ - 1; q >= 0; q--) begin
            if (r_pend[q]) begin
                sel = SW'(q);
            end
        end
    end

    always_comb begin
        n_la_hi = r_la_hi;
        n_la_lo = r_la_lo;
        n_lw_hi = r_lw_hi;
        n_lw_lo = r_lw_lo;
        ev      = '0;
        kind    = taem_pkg::KIND_OK;
        n_code  = r_code;
        for (int q = 0; q < NQ; q++) begin
            kind = taem_pkg::KIND_OK;
            if (i_cls.en[q]) begin
                if (i_cls.hi_a[q]) begin
                    ev[q] = !r_la_hi[q];
                    kind = taem_pkg::KIND_HI_ALARM;
                    n_la_hi[q] = 1'b1;
                end else if (i_cls.hi_w[q]) begin
                    ev[q] = !r_lw_hi[q];
                    kind = taem_pkg::KIND_HI_WARN;
                    n_lw_hi[q] = 1'b1;
                end else if (i_cls.lo_a[q]) begin
                    ev[q] = !r_la_lo[q];
                    kind = taem_pkg::KIND_LO_ALARM;
                    n_la_lo[q] = 1'b1;
                end else if (i_cls.lo_w[q]) begin
                    ev[q] = !r_lw_lo[q];
                    kind = taem_pkg::KIND_LO_WARN;
                    n_lw_lo[q] = 1'b1;
                end else begin
                    ev[q] = r_la_hi[q] | r_la_lo[q] | r_lw_hi[q] | r_lw_lo[q];
                    kind = taem_pkg::KIND_OK;
                    n_la_hi[q] = 1'b0;
                    n_la_lo[q] = 1'b0;
                    n_lw_hi[q] = 1'b0;
                    n_lw_lo[q] = 1'b0;
                end
            end
            n_code[q] = taem_pkg::CODE_W'(q * 5) + taem_pkg::CODE_W'(kind);
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (o_pop) begin
            n_pend = ev;
        end else if (send) begin
            n_pend = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la_hi     <= '0;
            r_la_lo     <= '0;
            r_lw_hi     <= '0;
            r_lw_lo     <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (o_pop) begin
                r_la_hi <= n_la_hi;
                r_la_lo <= n_la_lo;
                r_lw_hi <= n_lw_hi;
                r_lw_lo <= n_lw_lo;
            end
            if (send) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code <= n_code;
        end
        if (send) begin
            r_out.port       <= i_port_tag;
            r_out.event_code <= r_code[sel];
            r_out.last       <= (rest == '0);
        end
    end

endmodule

// ===== sv/transceiver_alarm_event_monitor.sv =====
// channel   | valid       | ready       | payload
// ----------+-------------+-------------+-------------------------------
// input     | i_valid     | o_ready     | i_item  (taem_pkg::t_in)
// result    | o_valid     | i_ready     | o_item  (taem_pkg::t_out)
// config    | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// A snapshot is classified in its accept cycle and queued. The event stage
// pops it once every event of the previous snapshot is sent, then sends its
// events one per cycle while the receiver is ready: N = 0..7 events per
// snapshot, each pop followed by one output beat per event.
// A stalled receiver holds the event register; the queue then fills and
// o_ready drops. Reset is synchronous and active low; config is always ready.
module transceiver_alarm_event_monitor #(
    parameter int QUEUE_DEPTH = taem_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  taem_pkg::t_in                   i_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output taem_pkg::t_out                  o_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [taem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [taem_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [taem_pkg::PORT_W-1:0] r_port_tag;
    taem_pkg::t_cfg              r_cfg;
    taem_pkg::t_cls              push_cls, pop_cls;
    logic                        push, pop, full, avail;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_tag <= '0;
            r_cfg      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                taem_pkg::REG_PORT_TAG: begin
                    r_port_tag <= i_cfg_data[taem_pkg::PORT_W-1:0];
                end
                taem_pkg::REG_MODULE_OPTIONS: begin
                    r_cfg.options <= i_cfg_data[taem_pkg::OPT_W-1:0];
                end
                taem_pkg::REG_TEMP_LIMITS:    r_cfg.limits[0] <= i_cfg_data;
                taem_pkg::REG_VCC_LIMITS:     r_cfg.limits[1] <= i_cfg_data;
                taem_pkg::REG_BIAS_LIMITS:    r_cfg.limits[2] <= i_cfg_data;
                taem_pkg::REG_TXPOWER_LIMITS: r_cfg.limits[3] <= i_cfg_data;
                taem_pkg::REG_RXPOWER_LIMITS: r_cfg.limits[4] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    taem_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_cls   (push_cls)
    );

    taem_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cls),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_cls),
        .o_avail (avail)
    );

    taem_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (avail),
        .i_cls      (pop_cls),
        .o_pop      (pop),
        .i_port_tag (r_port_tag),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

endmodule
